[hdl/gba_pkg.sv]
package gba_pkg;

   // grid geometry
   localparam int TIME_SLOTS = 4;
   localparam int GRID_ROWS  = 256;
   localparam int GRID_COLS  = 256;
   localparam int CELLS      = TIME_SLOTS * GRID_ROWS * GRID_COLS;
   localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;

   // cell word: running sum above sample count
   localparam int SUM_W   = 48;
   localparam int COUNT_W = 16;
   localparam int CELL_W  = SUM_W + COUNT_W;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // shared divider
   localparam int DIV_N_W    = 48;
   localparam int DIV_D_W    = 16;
   localparam int DIV_STEP_W = $clog2(DIV_N_W);

   // configuration register map
   localparam logic [2:0] REG_LAT_ORIGIN    = 3'd0;
   localparam logic [2:0] REG_LON_ORIGIN    = 3'd1;
   localparam logic [2:0] REG_CELL_SIZE     = 3'd2;
   localparam logic [2:0] REG_ROWS_USED     = 3'd3;
   localparam logic [2:0] REG_COLS_USED     = 3'd4;
   localparam logic [2:0] REG_SLOTS_USED    = 3'd5;
   localparam logic [2:0] REG_MISSING_FLOOR = 3'd6;

   // operation codes
   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READOUT    = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC_LAT,
      ST_ACC_LAT_W,
      ST_ACC_LON,
      ST_ACC_LON_W,
      ST_ACC_ADDR,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_RD_COL,
      ST_RD_COL_W,
      ST_RD_ROW,
      ST_RD_ROW_W,
      ST_RD_ADDR,
      ST_RD_MEM,
      ST_RD_DATA,
      ST_RD_MEAN,
      ST_RD_MEAN_W,
      ST_EMIT
   } state_type;

endpackage

[hdl/gba_ram.sv]
module gba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/gba_div.sv]
module gba_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gba_pkg::DIV_N_W-1:0] dividend,
   input  logic [gba_pkg::DIV_D_W-1:0] divisor,
   output logic                        done,
   output logic [gba_pkg::DIV_N_W-1:0] quotient,
   output logic [gba_pkg::DIV_D_W-1:0] remainder
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [gba_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic [gba_pkg::DIV_N_W-1:0]    quo_ff, quo_in;
   logic [gba_pkg::DIV_D_W-1:0]    rem_ff, rem_in;
   logic [gba_pkg::DIV_D_W-1:0]    dvs_ff, dvs_in;
   logic [gba_pkg::DIV_D_W:0]      trial;
   logic [gba_pkg::DIV_D_W:0]      diff;
   logic                           fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[gba_pkg::DIV_N_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = !diff[gba_pkg::DIV_D_W];
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[gba_pkg::DIV_N_W-2:0], fits};
         rem_in  = fits ? diff[gba_pkg::DIV_D_W-1:0] : trial[gba_pkg::DIV_D_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == gba_pkg::DIV_STEP_W'(gba_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[hdl/gridded_bin_average_core.sv]
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  op, time_slot, lat_fix, lon_fix, sample_value
// rsp_      out        rsp_valid/rsp_stall  out_slot, out_row, out_col, cell_mean,
//                                           cell_count, last_cell
// csr_      in         csr_we               csr_index, csr_wdata
//
// one transaction is worked at a time; every division runs on one shared
// 48-step bit-serial divider
// accumulate: up to 2 divisions plus the cell read-modify-write (address, read and write states)
// readout: 2 divisions to split the pointer, 1 for the mean when the cell count is nonzero
// after reset a clearing pass writes every cell, with req_stall high
// a finished readout waits in the rsp register; a new transaction is taken meanwhile
module gridded_bin_average_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [1:0]         req_time_slot,
   input  logic signed [15:0] req_lat_fix,
   input  logic signed [17:0] req_lon_fix,
   input  logic signed [31:0] req_sample_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_slot,
   output logic [7:0]         rsp_out_row,
   output logic [7:0]         rsp_out_col,
   output logic signed [31:0] rsp_cell_mean,
   output logic [15:0]        rsp_cell_count,
   output logic               rsp_last_cell,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int AW = gba_pkg::ADDR_W;
   localparam int NW = gba_pkg::DIV_N_W;
   localparam int DW = gba_pkg::DIV_D_W;

   // configuration registers
   logic signed [15:0] lat_origin_ff;
   logic signed [17:0] lon_origin_ff;
   logic [15:0]        cell_size_ff;
   logic [8:0]         rows_used_ff;
   logic [8:0]         cols_used_ff;
   logic [2:0]         slots_used_ff;
   logic signed [31:0] missing_floor_ff;

   gba_pkg::state_type state_ff, state_in;

   // working registers
   logic                   op_ff, op_in;
   logic signed [16:0]     lat_off_ff, lat_off_in;
   logic signed [18:0]     lon_off_ff, lon_off_in;
   logic signed [31:0]     value_ff, value_in;
   logic [15:0]            slot_ff, slot_in;
   logic [15:0]            row_ff, row_in;
   logic [15:0]            col_ff, col_in;
   logic [NW-1:0]          q1_ff, q1_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic                   neg_ff, neg_in;
   logic [gba_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [gba_pkg::SUM_W-1:0]   mag_ff, mag_in;
   logic signed [31:0]     mean_ff, mean_in;
   logic                   last_ff, last_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_slot_ff;
   logic [7:0]  rsp_row_ff;
   logic [7:0]  rsp_col_ff;
   logic signed [31:0] rsp_mean_ff;
   logic [15:0] rsp_count_ff;
   logic        rsp_last_ff;
   logic        rsp_load;

   // clamped used sizes
   logic [15:0] rows_eff, cols_eff, slots_eff;

   // divider and memory hookup
   logic          div_start;
   logic [NW-1:0] div_dividend;
   logic [DW-1:0] div_divisor;
   logic          div_done;
   logic [NW-1:0] div_quo;
   logic [DW-1:0] div_rem;

   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [gba_pkg::CELL_W-1:0] mem_wdata;
   logic [gba_pkg::CELL_W-1:0] mem_rdata;
   logic signed [gba_pkg::SUM_W-1:0]   rd_sum;
   logic [gba_pkg::COUNT_W-1:0]        rd_cnt;
   logic signed [gba_pkg::SUM_W-1:0]   new_sum;
   logic [NW-1:0]                      mean_q;

   assign rd_sum  = mem_rdata[gba_pkg::CELL_W-1:gba_pkg::COUNT_W];
   assign rd_cnt  = mem_rdata[gba_pkg::COUNT_W-1:0];
   assign new_sum = rd_sum + {{(gba_pkg::SUM_W-32){value_ff[31]}}, value_ff};

   always_comb begin
      if (rows_used_ff == '0) begin
         rows_eff = 16'd1;
      end else if ({7'd0, rows_used_ff} > 16'(gba_pkg::GRID_ROWS)) begin
         rows_eff = 16'(gba_pkg::GRID_ROWS);
      end else begin
         rows_eff = {7'd0, rows_used_ff};
      end
      if (cols_used_ff == '0) begin
         cols_eff = 16'd1;
      end else if ({7'd0, cols_used_ff} > 16'(gba_pkg::GRID_COLS)) begin
         cols_eff = 16'(gba_pkg::GRID_COLS);
      end else begin
         cols_eff = {7'd0, cols_used_ff};
      end
      if (slots_used_ff == '0) begin
         slots_eff = 16'd1;
      end else if ({13'd0, slots_used_ff} > 16'(gba_pkg::TIME_SLOTS)) begin
         slots_eff = 16'(gba_pkg::TIME_SLOTS);
      end else begin
         slots_eff = {13'd0, slots_used_ff};
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_origin_ff    <= 16'sd1280;
         lon_origin_ff    <= 18'sd16640;
         cell_size_ff     <= 16'd64;
         rows_used_ff     <= 9'd140;
         cols_used_ff     <= 9'd140;
         slots_used_ff    <= 3'd4;
         missing_floor_ff <= -32'sd589824000;
      end else if (csr_we) begin
         case (csr_index)
            gba_pkg::REG_LAT_ORIGIN:    lat_origin_ff    <= csr_wdata[15:0];
            gba_pkg::REG_LON_ORIGIN:    lon_origin_ff    <= csr_wdata[17:0];
            gba_pkg::REG_CELL_SIZE:     cell_size_ff     <= csr_wdata[15:0];
            gba_pkg::REG_ROWS_USED:     rows_used_ff     <= csr_wdata[8:0];
            gba_pkg::REG_COLS_USED:     cols_used_ff     <= csr_wdata[8:0];
            gba_pkg::REG_SLOTS_USED:    slots_used_ff    <= csr_wdata[2:0];
            gba_pkg::REG_MISSING_FLOOR: missing_floor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      lat_off_in   = lat_off_ff;
      lon_off_in   = lon_off_ff;
      value_in     = value_ff;
      slot_in      = slot_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      q1_in        = q1_ff;
      addr_in      = addr_ff;
      ptr_in       = ptr_ff;
      clr_in       = clr_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      mean_in      = mean_ff;
      last_in      = last_ff;
      req_stall    = 1'b1;
      rsp_load     = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = cell_size_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      mean_q       = '0;
      case (state_ff)
         gba_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(gba_pkg::CELLS - 1)) begin
               state_in = gba_pkg::ST_IDLE;
            end
         end
         gba_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in      = req_op;
               slot_in    = {14'd0, req_time_slot};
               lat_off_in = {req_lat_fix[15], req_lat_fix}
                            - {lat_origin_ff[15], lat_origin_ff};
               lon_off_in = {req_lon_fix[17], req_lon_fix}
                            - {lon_origin_ff[17], lon_origin_ff};
               value_in   = req_sample_value;
               state_in   = (req_op == gba_pkg::OP_READOUT) ? gba_pkg::ST_RD_COL
                                                            : gba_pkg::ST_ACC_LAT;
            end
         end
         gba_pkg::ST_ACC_LAT: begin
            // early drops: no grid, west or south of origin, unused slot, missing value
            if (cell_size_ff == '0 || lat_off_ff < 0 || lon_off_ff < 0
                || slot_ff >= slots_eff || value_ff <= missing_floor_ff) begin
               state_in = gba_pkg::ST_IDLE;
            end else begin
               div_start         = 1'b1;
               div_dividend[16:0] = lat_off_ff;
               state_in          = gba_pkg::ST_ACC_LAT_W;
            end
         end
         gba_pkg::ST_ACC_LAT_W: begin
            if (div_done) begin
               row_in   = div_quo[15:0];
               state_in = (div_quo >= NW'(rows_eff)) ? gba_pkg::ST_IDLE
                                                     : gba_pkg::ST_ACC_LON;
            end
         end
         gba_pkg::ST_ACC_LON: begin
            div_start          = 1'b1;
            div_dividend[18:0] = lon_off_ff;
            state_in           = gba_pkg::ST_ACC_LON_W;
         end
         gba_pkg::ST_ACC_LON_W: begin
            if (div_done) begin
               col_in   = div_quo[15:0];
               state_in = (div_quo >= NW'(cols_eff)) ? gba_pkg::ST_IDLE
                                                     : gba_pkg::ST_ACC_ADDR;
            end
         end
         gba_pkg::ST_ACC_ADDR, gba_pkg::ST_RD_ADDR: begin
            addr_in  = AW'((AW'(slot_ff) * AW'(gba_pkg::GRID_ROWS) + AW'(row_ff))
                           * AW'(gba_pkg::GRID_COLS) + AW'(col_ff));
            state_in = (state_ff == gba_pkg::ST_ACC_ADDR) ? gba_pkg::ST_ACC_RD
                                                          : gba_pkg::ST_RD_MEM;
         end
         gba_pkg::ST_ACC_RD: begin
            // memory samples addr_ff this cycle
            state_in = gba_pkg::ST_ACC_WR;
         end
         gba_pkg::ST_ACC_WR: begin
            // a full cell takes no more samples
            if (rd_cnt != gba_pkg::COUNT_MAX) begin
               mem_we    = 1'b1;
               mem_wdata = {new_sum, rd_cnt + 1'b1};
            end
            state_in = gba_pkg::ST_IDLE;
         end
         gba_pkg::ST_RD_COL: begin
            div_start          = 1'b1;
            div_dividend[AW-1:0] = ptr_ff;
            div_divisor        = cols_eff;
            state_in           = gba_pkg::ST_RD_COL_W;
         end
         gba_pkg::ST_RD_COL_W: begin
            if (div_done) begin
               col_in   = div_rem;
               q1_in    = div_quo;
               state_in = gba_pkg::ST_RD_ROW;
            end
         end
         gba_pkg::ST_RD_ROW: begin
            div_start    = 1'b1;
            div_dividend = q1_ff;
            div_divisor  = rows_eff;
            state_in     = gba_pkg::ST_RD_ROW_W;
         end
         gba_pkg::ST_RD_ROW_W: begin
            if (div_done) begin
               row_in  = div_rem;
               slot_in = div_quo[15:0];
               // pointer past the pass after a register change: restart at cell zero
               if (div_quo >= NW'(slots_eff)) begin
                  row_in  = '0;
                  col_in  = '0;
                  slot_in = '0;
                  ptr_in  = '0;
               end
               state_in = gba_pkg::ST_RD_ADDR;
            end
         end
         gba_pkg::ST_RD_MEM: begin
            state_in = gba_pkg::ST_RD_DATA;
         end
         gba_pkg::ST_RD_DATA: begin
            cnt_in  = rd_cnt;
            neg_in  = rd_sum[gba_pkg::SUM_W-1];
            mag_in  = rd_sum[gba_pkg::SUM_W-1] ? -rd_sum : rd_sum;
            last_in = (slot_ff == slots_eff - 1'b1) && (row_ff == rows_eff - 1'b1)
                      && (col_ff == cols_eff - 1'b1);
            ptr_in  = last_in ? '0 : ptr_ff + 1'b1;
            mean_in = '0;
            state_in = (rd_cnt == '0) ? gba_pkg::ST_EMIT : gba_pkg::ST_RD_MEAN;
         end
         gba_pkg::ST_RD_MEAN: begin
            div_start    = 1'b1;
            div_dividend = mag_ff;
            div_divisor  = cnt_ff;
            state_in     = gba_pkg::ST_RD_MEAN_W;
         end
         gba_pkg::ST_RD_MEAN_W: begin
            if (div_done) begin
               // truncate toward zero: divide magnitudes, then restore the sign
               mean_q   = neg_ff ? -div_quo : div_quo;
               mean_in  = mean_q[31:0];
               state_in = gba_pkg::ST_EMIT;
            end
         end
         gba_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = gba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gba_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gba_pkg::ST_CLEAR;
         clr_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      lat_off_ff <= lat_off_in;
      lon_off_ff <= lon_off_in;
      value_ff   <= value_in;
      slot_ff    <= slot_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      q1_ff      <= q1_in;
      addr_ff    <= addr_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
      mag_ff     <= mag_in;
      mean_ff    <= mean_in;
      last_ff    <= last_in;
      if (rsp_load) begin
         rsp_slot_ff  <= slot_ff[1:0];
         rsp_row_ff   <= row_ff[7:0];
         rsp_col_ff   <= col_ff[7:0];
         rsp_mean_ff  <= mean_ff;
         rsp_count_ff <= cnt_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   gba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // one word per cell: sum above count
   gba_ram #(
      .WIDTH (gba_pkg::CELL_W),
      .DEPTH (gba_pkg::CELLS)
   ) u_cells (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (addr_ff),
      .rdata (mem_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_slot   = rsp_slot_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_cell_mean  = rsp_mean_ff;
   assign rsp_cell_count = rsp_count_ff;
   assign rsp_last_cell  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == gba_pkg::ST_CLEAR |-> req_stall)
      else $error("transaction taken during clearing pass");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == gba_pkg::ST_CLEAR || state_ff == gba_pkg::ST_ACC_WR))
      else $error("cell write outside clear or accumulate");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending result overwritten");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != gba_pkg::ST_IDLE)
      else $error("accepted transaction not started");

   a_readout_op: assert property (@(posedge clock) disable iff (reset)
      state_ff == gba_pkg::ST_RD_COL |-> op_ff == gba_pkg::OP_READOUT)
      else $error("readout started for accumulate op");
`endif

endmodule
